FILE: src/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// An antecedent that implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  `ASSERT_CLK(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

FILE: src/psadpcm_pkg.sv
package psadpcm_pkg;

  localparam int unsigned FrameSamples = 28;
  localparam int unsigned CntW         = $clog2(FrameSamples);
  localparam int unsigned NibW         = 4;
  localparam int unsigned NibBitsW     = FrameSamples * NibW;
  localparam int unsigned SampleW      = 16;
  localparam int unsigned CoefW        = 8;
  localparam int unsigned MaxPredIdx   = 4;

  localparam logic [7:0]  EndMarkerFlags = 8'd7;
  localparam logic signed [SampleW-1:0] SampleMax = 16'sd32767;
  localparam logic signed [SampleW-1:0] SampleMin = -16'sd32768;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

  typedef logic signed [CoefW-1:0] coef_t;

  function automatic coef_t coef_a(input logic [2:0] idx);
    coef_t c;
    case (idx)
      3'd1:    c = 8'sd60;
      3'd2:    c = 8'sd115;
      3'd3:    c = 8'sd98;
      3'd4:    c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  function automatic coef_t coef_b(input logic [2:0] idx);
    coef_t c;
    case (idx)
      3'd2:    c = -8'sd52;
      3'd3:    c = -8'sd55;
      3'd4:    c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

FILE: src/ps_adpcm_frame_decoder.sv
// PS-ADPCM frame decoder. The slave stream takes one 16-byte frame per
// transfer; the master stream returns its 28 decoded samples, one per
// transfer, tlast on the 28th and tuser on the 28th when the frame ends
// the sound. A frame that starts a sound carries tuser high; tlast on the
// input marks the last whole frame of the buffer.
// A frame is accepted and, while the receiver does not stall, its samples
// then leave one a cycle through a single multiply-accumulate and saturate
// unit that is stepped by a sample counter; the input is ready again as
// soon as the last sample has been registered.
// The first sample is computed in the run state and registered into the
// output register once that register is free. End marker frames and frames
// after the end of a sound produce nothing and leave the input ready.
// A stalled receiver holds the output register and freezes the counter;
// the next frame can be taken while the last sample still waits.
// Reset clears the history, the end state and all valid flags.
module ps_adpcm_frame_decoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // frame_header [7:0], frame_flags [15:8], nibbles_low [71:16],
  // nibbles_high [127:72]
  input  logic [127:0] s_axis_tdata,
  // starts_sound
  input  logic         s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // sample [15:0]
  output logic [15:0]  m_axis_tdata,
  // end_of_sound
  output logic         m_axis_tuser,
  output logic         m_axis_tlast
);

  localparam int unsigned SW = psadpcm_pkg::SampleW;
  localparam int unsigned CW = psadpcm_pkg::CntW;
  localparam int unsigned PW = SW + psadpcm_pkg::CoefW;

  psadpcm_pkg::state_e state_q, state_d;
  logic [psadpcm_pkg::NibBitsW-1:0] nib_q, nib_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [2:0] pidx_q, pidx_d;
  logic [3:0] shift_q, shift_d;
  logic ends_q, ends_d;
  logic finished_q, finished_d;
  logic signed [SW-1:0] s1_q, s1_d, s2_q, s2_d;
  logic m_valid_q, m_valid_d;
  logic [SW-1:0] m_data_q, m_data_d;
  logic m_last_q, m_last_d, m_user_q, m_user_d;

  logic s_take, advance, last_step, fin_eff;
  logic [7:0] hdr, flags;
  logic [3:0] hdr_pidx;
  logic signed [SW-1:0] scaled, sample;
  logic signed [PW-1:0] prod_a, prod_b;
  logic signed [PW:0] pred;
  logic signed [PW-6:0] pred_sh;
  logic signed [PW-5:0] sum;

  assign hdr      = s_axis_tdata[7:0];
  assign flags    = s_axis_tdata[15:8];
  assign hdr_pidx = hdr[7:4];

  assign s_axis_tready = (state_q == psadpcm_pkg::StIdle);
  assign s_take        = s_axis_tvalid && s_axis_tready;
  assign advance       = (state_q == psadpcm_pkg::StRun) && (!m_valid_q || m_axis_tready);
  assign last_step     = (cnt_q == CW'(psadpcm_pkg::FrameSamples - 1));
  assign fin_eff       = s_axis_tuser ? 1'b0 : finished_q;

  assign scaled  = $signed({nib_q[3:0], 12'b0}) >>> shift_q;
  assign prod_a  = s1_q * psadpcm_pkg::coef_a(pidx_q);
  assign prod_b  = s2_q * psadpcm_pkg::coef_b(pidx_q);
  assign pred    = (PW+1)'(prod_a) + (PW+1)'(prod_b) + (PW+1)'(32);
  assign pred_sh = pred[PW:6];
  assign sum     = (PW-4)'(scaled) + (PW-4)'(pred_sh);

  always_comb begin
    if (sum > (PW-4)'(psadpcm_pkg::SampleMax)) begin
      sample = psadpcm_pkg::SampleMax;
    end else if (sum < (PW-4)'(psadpcm_pkg::SampleMin)) begin
      sample = psadpcm_pkg::SampleMin;
    end else begin
      sample = sum[SW-1:0];
    end
  end

  always_comb begin
    state_d    = state_q;
    nib_d      = nib_q;
    cnt_d      = cnt_q;
    pidx_d     = pidx_q;
    shift_d    = shift_q;
    ends_d     = ends_q;
    finished_d = finished_q;
    s1_d       = s1_q;
    s2_d       = s2_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    m_last_d   = m_last_q;
    m_user_d   = m_user_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      psadpcm_pkg::StIdle: begin
        if (s_take) begin
          if (s_axis_tuser) begin
            s1_d       = '0;
            s2_d       = '0;
            finished_d = 1'b0;
          end
          if (!fin_eff) begin
            if (flags == psadpcm_pkg::EndMarkerFlags) begin
              finished_d = 1'b1;
            end else begin
              nib_d   = s_axis_tdata[127:16];
              cnt_d   = '0;
              pidx_d  = (hdr_pidx > 4'(psadpcm_pkg::MaxPredIdx)) ?
                        3'(psadpcm_pkg::MaxPredIdx) : hdr_pidx[2:0];
              shift_d = hdr[3:0];
              ends_d  = flags[0] || s_axis_tlast;
              state_d = psadpcm_pkg::StRun;
            end
          end
        end
      end
      psadpcm_pkg::StRun: begin
        if (advance) begin
          m_valid_d = 1'b1;
          m_data_d  = sample;
          m_last_d  = last_step;
          m_user_d  = last_step && ends_q;
          s2_d      = s1_q;
          s1_d      = sample;
          nib_d     = nib_q >> psadpcm_pkg::NibW;
          cnt_d     = cnt_q + CW'(1);
          if (last_step) begin
            state_d = psadpcm_pkg::StIdle;
            if (ends_q) begin
              finished_d = 1'b1;
            end
          end
        end
      end
      default: state_d = psadpcm_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= psadpcm_pkg::StIdle;
      finished_q <= 1'b0;
      s1_q       <= '0;
      s2_q       <= '0;
      m_valid_q  <= 1'b0;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      finished_q <= finished_d;
      s1_q       <= s1_d;
      s2_q       <= s2_d;
      m_valid_q  <= m_valid_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nib_q    <= nib_d;
    pidx_q   <= pidx_d;
    shift_q  <= shift_d;
    ends_q   <= ends_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_user_q;

endmodule

FILE: src/psadpcm_checker.sv
`include "assert_macros.svh"

module psadpcm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  localparam int unsigned SW = psadpcm_pkg::SampleW;

  logic [SW-1:0] sample;

  assign sample = m_axis_tdata[SW-1:0];

  // A stalled sample stays on the bus unchanged.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable(sample), "stalled sample changed")

  // No new frame is taken while a frame is still only partly delivered.
  `ASSERT_CLK(a_no_take_mid_frame, clk_i, rst_ni,
              (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready,
              "input ready in the middle of a frame")

  // The end of a sound is only flagged on the final sample of a frame.
  `ASSERT_CLK(a_end_on_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast,
              "end of sound away from the end of a frame")

  // Within a frame the samples follow each other without gaps.
  `ASSERT_NEXT(a_no_gap, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
               m_axis_tvalid, "gap inside a frame")

endmodule

bind ps_adpcm_frame_decoder psadpcm_checker u_psadpcm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: dv/ps_adpcm_frame_decoder_tb.sv
module ps_adpcm_frame_decoder_tb;

  typedef enum int {
    ModeSteady,
    ModeSenderGaps,
    ModeReceiverStalls,
    ModeBothGaps
  } idle_mode_e;

  typedef struct {
    bit          start;
    bit          fin;
    logic [7:0]  hdr;
    logic [7:0]  flags;
    logic [55:0] lo;
    logic [55:0] hi;
    idle_mode_e  mode;
  } frame_t;

  typedef struct {
    logic [15:0] pcm;
    logic        last;
    logic        eos;
  } pcm_t;

  localparam int StuckLimit   = 2000;
  localparam int HoldCycles   = 300;
  localparam int LiveTarget   = 360;
  localparam int DrainCycles  = 40;
  localparam int PrintLimit   = 200;

  localparam int CoefA [5] = '{0, 60, 115, 98, 122};
  localparam int CoefB [5] = '{0, 0, -52, -55, -60};

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata  = '0;
  logic         s_axis_tuser  = 1'b0;
  logic         s_axis_tlast  = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  frame_t     frame_queue[$];
  pcm_t       pcm_expected[$];
  frame_t     frame_on_bus;
  idle_mode_e cur_mode     = ModeSteady;
  idle_mode_e gen_mode     = ModeSteady;
  bit         gen_done     = 1'b0;
  int         live_frames  = 0;
  bit         frame_taken  = 1'b0;
  bit         rx_hold      = 1'b0;
  int         frames_taken = 0;
  int         mismatches   = 0;
  int         stuck_cycles = 0;

  int hist1    = 0;
  int hist2    = 0;
  bit snd_done = 1'b0;

  ps_adpcm_frame_decoder DUT (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit chance(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic [55:0] rand_codes();
    logic [3:0] nib;
    if (chance(10)) begin
      nib = chance(50) ? 4'h7 : 4'h8;
      return {14{nib}};
    end
    return 56'({$urandom, $urandom});
  endfunction

  function automatic logic [7:0] rand_header();
    logic [3:0] pred;
    logic [3:0] shift;
    pred  = chance(85) ? 4'($urandom_range(0, 4)) : 4'($urandom_range(5, 15));
    shift = chance(85) ? 4'($urandom_range(0, 12)) : 4'($urandom_range(13, 15));
    return {pred, shift};
  endfunction

  function automatic logic [7:0] mid_flags();
    logic [7:0] fl;
    fl = 8'($urandom_range(255));
    return fl & 8'hFE;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PrintLimit) $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic add_frame(input bit start, input bit fin, input logic [7:0] hdr,
                           input logic [7:0] flags, input logic [55:0] lo,
                           input logic [55:0] hi);
    frame_t f;
    f.start = start;
    f.fin   = fin;
    f.hdr   = hdr;
    f.flags = flags;
    f.lo    = lo;
    f.hi    = hi;
    f.mode  = gen_mode;
    frame_queue.push_back(f);
    if (start) gen_done = 1'b0;
    if (!gen_done) begin
      live_frames++;
      if (flags == psadpcm_pkg::EndMarkerFlags || flags[0] || fin) gen_done = 1'b1;
    end
  endtask

  // Works out the samples of one accepted frame and updates the history.
  task automatic decode_frame(input frame_t f);
    logic [111:0] codes;
    int           nib;
    int           acc;
    int           pred;
    int           idx;
    bit           ends;
    pcm_t         r;
    if (f.start) begin
      hist1    = 0;
      hist2    = 0;
      snd_done = 1'b0;
    end
    if (snd_done) return;
    if (f.flags == psadpcm_pkg::EndMarkerFlags) begin
      snd_done = 1'b1;
      return;
    end
    idx   = (f.hdr[7:4] > psadpcm_pkg::MaxPredIdx) ? psadpcm_pkg::MaxPredIdx : f.hdr[7:4];
    ends  = f.flags[0] || f.fin;
    codes = {f.hi, f.lo};
    for (int i = 0; i < psadpcm_pkg::FrameSamples; i++) begin
      nib  = $signed(codes[4*i +: 4]);
      acc  = (nib * 4096) >>> f.hdr[3:0];
      pred = hist1 * CoefA[idx] + hist2 * CoefB[idx] + 32;
      acc  = acc + (pred >>> 6);
      if (acc > int'(psadpcm_pkg::SampleMax)) acc = int'(psadpcm_pkg::SampleMax);
      if (acc < int'(psadpcm_pkg::SampleMin)) acc = int'(psadpcm_pkg::SampleMin);
      hist2  = hist1;
      hist1  = acc;
      r.pcm  = acc[15:0];
      r.last = (i == psadpcm_pkg::FrameSamples - 1);
      r.eos  = r.last && ends;
      pcm_expected.push_back(r);
    end
    if (ends) snd_done = 1'b1;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || frame_taken)) begin
      if (frame_queue.size() != 0 &&
          !(frame_queue[0].mode == ModeSenderGaps && chance(46)) &&
          !(frame_queue[0].mode == ModeBothGaps && chance(13))) begin
        frame_on_bus = frame_queue.pop_front();
        cur_mode     = frame_on_bus.mode;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {frame_on_bus.hi, frame_on_bus.lo, frame_on_bus.flags,
                          frame_on_bus.hdr};
        s_axis_tuser  <= frame_on_bus.start;
        s_axis_tlast  <= frame_on_bus.fin;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rx_hold)
      m_axis_tready <= 1'b0;
    else if (cur_mode == ModeReceiverStalls)
      m_axis_tready <= !chance(46);
    else if (cur_mode == ModeBothGaps)
      m_axis_tready <= !chance(13);
    else
      m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    pcm_t exp_pcm;
    frame_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (frame_taken) begin
      decode_frame(frame_on_bus);
      frames_taken++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pcm_expected.size() == 0) begin
        report_mismatch($sformatf("sample %h with nothing expected", m_axis_tdata));
      end else begin
        exp_pcm = pcm_expected.pop_front();
        if (m_axis_tdata !== exp_pcm.pcm)
          report_mismatch($sformatf("sample %h, expected %h", m_axis_tdata, exp_pcm.pcm));
        if (m_axis_tlast !== exp_pcm.last)
          report_mismatch($sformatf("tlast %b, expected %b", m_axis_tlast, exp_pcm.last));
        if (m_axis_tuser !== exp_pcm.eos)
          report_mismatch($sformatf("tuser %b, expected %b", m_axis_tuser, exp_pcm.eos));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, StuckLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // The receiver holds off long enough for the frame input to back up.
  initial begin
    wait (frames_taken >= 40);
    @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  initial begin
    int r;
    int n;
    logic [7:0] fl;

    add_frame(1, 0, 8'h00, 8'h00, {14{4'h7}}, {14{4'h7}});
    add_frame(0, 0, 8'h40, 8'h00, {14{4'h7}}, {14{4'h7}});
    add_frame(0, 0, 8'h40, 8'h00, {14{4'h8}}, {14{4'h8}});
    add_frame(0, 0, 8'h10, 8'h02, rand_codes(), rand_codes());
    add_frame(0, 0, 8'h2C, 8'h00, rand_codes(), rand_codes());
    add_frame(0, 0, 8'h3D, 8'h04, rand_codes(), rand_codes());
    add_frame(0, 0, 8'h4F, 8'h00, {14{4'h8}}, {14{4'h8}});
    add_frame(0, 0, 8'h5E, 8'h00, rand_codes(), rand_codes());
    add_frame(0, 0, 8'hF0, 8'h00, rand_codes(), rand_codes());
    add_frame(0, 0, 8'h00, 8'h00, '0, '0);
    add_frame(0, 0, 8'h20, 8'hFE, '1, '1);
    add_frame(0, 0, 8'h31, psadpcm_pkg::EndMarkerFlags, rand_codes(), rand_codes());
    add_frame(0, 0, 8'h10, 8'h00, rand_codes(), rand_codes());
    add_frame(1, 0, 8'h22, 8'h01, rand_codes(), rand_codes());
    add_frame(0, 1, 8'h10, 8'h00, rand_codes(), rand_codes());
    add_frame(1, 1, 8'h33, 8'h00, rand_codes(), rand_codes());
    add_frame(1, 0, 8'h41, 8'hFF, rand_codes(), rand_codes());
    add_frame(1, 0, 8'h40, psadpcm_pkg::EndMarkerFlags, rand_codes(), rand_codes());
    add_frame(1, 0, 8'h2A, 8'h06, rand_codes(), rand_codes());
    add_frame(0, 0, 8'h40, 8'h00, {14{4'h7}}, {14{4'h7}});
    add_frame(1, 0, 8'h40, 8'h00, rand_codes(), rand_codes());

    while (live_frames < LiveTarget) begin
      n = live_frames * 4 / LiveTarget;
      gen_mode = idle_mode_e'((n > 3) ? 3 : n);
      r = $urandom_range(99);
      if (r < 10) begin
        fl = (r < 3) ? psadpcm_pkg::EndMarkerFlags : 8'($urandom_range(255));
        add_frame(1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)),
                  fl, rand_codes(), rand_codes());
      end else begin
        add_frame(1, 0, rand_header(), mid_flags(), rand_codes(), rand_codes());
        n = $urandom_range(0, 6);
        repeat (n) add_frame(0, 0, rand_header(), mid_flags(), rand_codes(), rand_codes());
        r = $urandom_range(99);
        if (r < 30) begin
          fl = mid_flags() | 8'h01;
          if (fl == psadpcm_pkg::EndMarkerFlags) fl = 8'h01;
          add_frame(0, 0, rand_header(), fl, rand_codes(), rand_codes());
        end else if (r < 55) begin
          add_frame(0, 1, rand_header(), mid_flags(), rand_codes(), rand_codes());
        end else if (r < 80) begin
          add_frame(0, 1'($urandom_range(1)), rand_header(), psadpcm_pkg::EndMarkerFlags,
                    rand_codes(), rand_codes());
        end
        if (chance(25))
          add_frame(0, 1'($urandom_range(1)), rand_header(), 8'($urandom_range(255)),
                    rand_codes(), rand_codes());
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (frame_queue.size() != 0 || s_axis_tvalid || pcm_expected.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (pcm_expected.size() != 0)
      report_mismatch($sformatf("%0d samples never arrived", pcm_expected.size()));

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
